>>> design/vnu_pkg.sv
// Package for the vector normalize unit: widths, mode codes and the structs
// passed between the lanes and the merge and normalize stages.
// Used by every module of the block; depends on nothing.
package vnu_pkg;

  localparam int COMP_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int WIDE_W   = 2 * COMP_W;
  localparam int NORM_POS = 31;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = ROOT_W + 2;
  localparam int QUO_W    = FRAC_W + 1;
  localparam int NUM_W    = ROOT_W + FRAC_W;
  localparam int SHIFT_W  = $clog2(WIDE_W);
  localparam int SQ_ST    = ROOT_W;
  localparam int DIV_ST   = QUO_W;
  localparam int PIPE_ST  = 1 + 2 + 6 + SQ_ST + DIV_ST;

  localparam logic [WIDE_W-1:0] NORM_TOP = WIDE_W'(1) << NORM_POS;
  localparam logic [COMP_W-1:0] RES_LIM  = COMP_W'((64'd1 << (COMP_W - 1)) - 64'd1);

  localparam logic [1:0] MODE_NORM_A     = 2'd0;
  localparam logic [1:0] MODE_NORM_DIFF  = 2'd1;
  localparam logic [1:0] MODE_NORM_CROSS = 2'd2;
  localparam logic [1:0] MODE_DOT        = 2'd3;

  typedef struct packed {
    logic              neg;
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] prod;
  } lane_out_t;

  typedef struct packed {
    logic              dot_mode;
    logic              zero;
    logic [2:0]        neg;
    logic [WIDE_W-1:0] dot;
  } side_t;

endpackage

>>> design/vector3_normalize_unit.sv
// Vector normalize unit top: input register, three component lanes, merge of
// the lanes (dot sum, largest magnitude, common shift), square root, dividers.
// Accepts one item per cycle while not stalled, set by the fully pipelined
// root (32 stages) and divider (17 stages).
// The pipeline holds only when a stalled result waits and the last stage is full.
// Reset (rst_n low, synchronous) clears all valid bits; data is not cleared.
module vector3_normalize_unit
  import vnu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic signed [COMP_W-1:0] in_a_x,
  input  logic signed [COMP_W-1:0] in_a_y,
  input  logic signed [COMP_W-1:0] in_a_z,
  input  logic signed [COMP_W-1:0] in_b_x,
  input  logic signed [COMP_W-1:0] in_b_y,
  input  logic signed [COMP_W-1:0] in_b_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COMP_W-1:0] out_res_x,
  output logic signed [COMP_W-1:0] out_res_y,
  output logic signed [COMP_W-1:0] out_res_z,
  output logic signed [WIDE_W-1:0] out_dot_value,
  output logic                     out_zero_length
);

  logic                     adv;
  logic [PIPE_ST-1:0]       vpipe_r;
  logic [1:0]               mode_r;
  logic signed [COMP_W-1:0] a_r [3];
  logic signed [COMP_W-1:0] b_r [3];
  lane_out_t                lo [3];

  side_t             side4_r, side5_r, side6_r, side7_r, side8_r, side9_r, side4_nxt;
  logic [WIDE_W-1:0] mag4_r [3];
  logic [WIDE_W-1:0] mag5_r [3];
  logic [WIDE_W-1:0] mag6_r [3];
  logic [WIDE_W-1:0] big4_r, big5_r, big4_nxt;
  logic [SHIFT_W-1:0] p5_r, p5_nxt;
  logic [SHIFT_W-1:0] amt6_r, amt6_nxt;
  logic               right6_r, right6_nxt;
  logic [COMP_W-1:0]  m7_r [3];
  logic [COMP_W-1:0]  m8_r [3];
  logic [COMP_W-1:0]  m9_r [3];
  logic [COMP_W-1:0]  m7_nxt [3];
  logic [WIDE_W-1:0]  sq8_r [3];
  logic [WIDE_W-1:0]  s9_r;
  logic signed [WIDE_W+1:0] dsum;
  logic [WIDE_W-1:0]  dot_sat;

  side_t             side_dl_r [SQ_ST + DIV_ST];
  logic [COMP_W-1:0] m_dl_r [SQ_ST][3];
  logic [ROOT_W-1:0] q_root;
  logic [QUO_W-1:0]  quo [3];
  side_t             side_end;

  logic                     out_valid_r;
  logic signed [COMP_W-1:0] res_r [3];
  logic signed [COMP_W-1:0] res_nxt [3];
  logic signed [WIDE_W-1:0] dot_r;
  logic                     zero_r;

  assign adv      = !out_valid_r || !out_stall || !vpipe_r[PIPE_ST-1];
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        vpipe_r <= {vpipe_r[PIPE_ST-2:0], in_valid};
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= vpipe_r[PIPE_ST-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r <= in_mode;
      a_r[0] <= in_a_x;
      a_r[1] <= in_a_y;
      a_r[2] <= in_a_z;
      b_r[0] <= in_b_x;
      b_r[1] <= in_b_y;
      b_r[2] <= in_b_z;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vnu_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .mode (mode_r),
      .a_i  (a_r[i]),
      .b_i  (b_r[i]),
      .a_j  (a_r[(i + 1) % 3]),
      .a_k  (a_r[(i + 2) % 3]),
      .b_j  (b_r[(i + 1) % 3]),
      .b_k  (b_r[(i + 2) % 3]),
      .lo   (lo[i])
    );
  end

  logic dot_mode3_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_mode3_r[0] <= (mode_r == MODE_DOT);
      dot_mode3_r[1] <= dot_mode3_r[0];
    end
  end

  assign dsum = (WIDE_W + 2)'($signed(lo[0].prod)) + (WIDE_W + 2)'($signed(lo[1].prod))
              + (WIDE_W + 2)'($signed(lo[2].prod));

  always_comb begin
    if (dsum[WIDE_W+1:WIDE_W-1] == 3'b000 || dsum[WIDE_W+1:WIDE_W-1] == 3'b111) begin
      dot_sat = WIDE_W'(dsum);
    end else if (dsum[WIDE_W+1]) begin
      dot_sat = {1'b1, {(WIDE_W - 1){1'b0}}};
    end else begin
      dot_sat = {1'b0, {(WIDE_W - 1){1'b1}}};
    end
    big4_nxt = lo[0].mag;
    if (lo[1].mag > big4_nxt) big4_nxt = lo[1].mag;
    if (lo[2].mag > big4_nxt) big4_nxt = lo[2].mag;
    side4_nxt.dot_mode = dot_mode3_r[1];
    side4_nxt.zero     = (big4_nxt == '0);
    side4_nxt.neg      = {lo[2].neg, lo[1].neg, lo[0].neg};
    side4_nxt.dot      = dot_sat;
  end

  always_comb begin
    p5_nxt = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (big4_r[i]) p5_nxt = SHIFT_W'(i);
    end
  end

  always_comb begin
    logic [SHIFT_W-1:0] rsh0;
    logic [WIDE_W-1:0]  tmp;
    logic               pow2;
    rsh0 = (p5_r >= SHIFT_W'(NORM_POS)) ? SHIFT_W'(p5_r - SHIFT_W'(NORM_POS)) : '0;
    tmp  = big5_r >> rsh0;
    pow2 = ((big5_r & (big5_r - WIDE_W'(1))) == '0);
    right6_nxt = (big5_r > NORM_TOP);
    if (right6_nxt) begin
      amt6_nxt = SHIFT_W'(rsh0 + SHIFT_W'(tmp != NORM_TOP));
    end else begin
      amt6_nxt = SHIFT_W'(SHIFT_W'(NORM_POS) - p5_r - SHIFT_W'(!pow2));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m7_nxt[i] = right6_r ? COMP_W'(mag6_r[i] >> amt6_r) : COMP_W'(mag6_r[i] << amt6_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4_r  <= side4_nxt;
      big4_r   <= big4_nxt;
      side5_r  <= side4_r;
      big5_r   <= big4_r;
      p5_r     <= p5_nxt;
      side6_r  <= side5_r;
      amt6_r   <= amt6_nxt;
      right6_r <= right6_nxt;
      side7_r  <= side6_r;
      side8_r  <= side7_r;
      side9_r  <= side8_r;
      s9_r     <= sq8_r[0] + sq8_r[1] + sq8_r[2];
      for (int i = 0; i < 3; i++) begin
        mag4_r[i] <= lo[i].mag;
        mag5_r[i] <= mag4_r[i];
        mag6_r[i] <= mag5_r[i];
        m7_r[i]   <= m7_nxt[i];
        m8_r[i]   <= m7_r[i];
        sq8_r[i]  <= WIDE_W'(m7_r[i]) * WIDE_W'(m7_r[i]);
        m9_r[i]   <= m8_r[i];
      end
    end
  end

  vnu_isqrt u_isqrt (
    .clk   (clk),
    .adv   (adv),
    .s_in  (s9_r),
    .q_out (q_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dl_r[0] <= side9_r;
      for (int k = 1; k < SQ_ST + DIV_ST; k++) begin
        side_dl_r[k] <= side_dl_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        m_dl_r[0][i] <= m9_r[i];
        for (int k = 1; k < SQ_ST; k++) begin
          m_dl_r[k][i] <= m_dl_r[k-1][i];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vnu_div u_div (
      .clk     (clk),
      .adv     (adv),
      .m_in    (m_dl_r[SQ_ST-1][i]),
      .q_in    (q_root),
      .quo_out (quo[i])
    );
  end

  assign side_end = side_dl_r[SQ_ST + DIV_ST - 1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [COMP_W-1:0] r;
      r = COMP_W'(quo[i]);
      if (r > RES_LIM) r = RES_LIM;
      if (side_end.dot_mode || side_end.zero) begin
        res_nxt[i] = '0;
      end else begin
        res_nxt[i] = side_end.neg[i] ? $signed(-r) : $signed(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= res_nxt[i];
      end
      dot_r  <= side_end.dot_mode ? $signed(side_end.dot) : '0;
      zero_r <= !side_end.dot_mode && side_end.zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = res_r[0];
  assign out_res_y       = res_r[1];
  assign out_res_z       = res_r[2];
  assign out_dot_value   = dot_r;
  assign out_zero_length = zero_r;

`ifndef ASSERT_OFF
  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_res_x == 0 && out_res_y == 0 && out_res_z == 0)
    else $error("zero-length item with nonzero result");

  a_dot_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dot_value != 0 |->
      out_res_x == 0 && out_res_y == 0 && out_res_z == 0 && !out_zero_length)
    else $error("dot item carries vector fields");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");
`endif

endmodule

>>> design/vnu_lane.sv
// One component lane: products for dot and cross, then selection of the
// vector component to normalize as sign and magnitude. Two stages.
// Depends on vnu_pkg.
module vnu_lane
  import vnu_pkg::*;
(
  input  logic                     clk,
  input  logic                     adv,
  input  logic [1:0]               mode,
  input  logic signed [COMP_W-1:0] a_i,
  input  logic signed [COMP_W-1:0] b_i,
  input  logic signed [COMP_W-1:0] a_j,
  input  logic signed [COMP_W-1:0] a_k,
  input  logic signed [COMP_W-1:0] b_j,
  input  logic signed [COMP_W-1:0] b_k,
  output lane_out_t                lo
);

  logic [1:0]               mode_r;
  logic signed [WIDE_W-1:0] pd_r, p1_r, p2_r;
  logic signed [WIDE_W-1:0] pd_nxt, p1_nxt, p2_nxt;
  logic signed [COMP_W:0]   diff_r, diff_nxt;
  logic signed [COMP_W-1:0] ai_r;
  logic signed [WIDE_W-1:0] vec;
  lane_out_t                lo_r, lo_nxt;

  assign pd_nxt   = a_i * b_i;
  assign p1_nxt   = a_j * b_k;
  assign p2_nxt   = b_j * a_k;
  assign diff_nxt = a_i - b_i;

  always_comb begin
    case (mode_r)
      MODE_NORM_A:     vec = WIDE_W'(ai_r);
      MODE_NORM_DIFF:  vec = WIDE_W'(diff_r);
      MODE_NORM_CROSS: vec = p1_r - p2_r;
      default:         vec = '0;
    endcase
    lo_nxt.neg  = vec[WIDE_W-1];
    lo_nxt.mag  = vec[WIDE_W-1] ? WIDE_W'(-vec) : WIDE_W'(vec);
    lo_nxt.prod = pd_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r <= mode;
      pd_r   <= pd_nxt;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      diff_r <= diff_nxt;
      ai_r   <= a_i;
      lo_r   <= lo_nxt;
    end
  end

  assign lo = lo_r;

endmodule

>>> design/vnu_isqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on vnu_pkg.
module vnu_isqrt
  import vnu_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [WIDE_W-1:0] s_in,
  output logic [ROOT_W-1:0] q_out
);

  logic [WIDE_W-1:0] s_r    [SQ_ST];
  logic [REM_W-1:0]  rem_r  [SQ_ST];
  logic [ROOT_W-1:0] root_r [SQ_ST];
  logic [WIDE_W-1:0] s_nxt    [SQ_ST];
  logic [REM_W-1:0]  rem_nxt  [SQ_ST];
  logic [ROOT_W-1:0] root_nxt [SQ_ST];

  always_comb begin
    for (int k = 0; k < SQ_ST; k++) begin
      logic [WIDE_W-1:0] sp;
      logic [REM_W-1:0]  rp;
      logic [ROOT_W-1:0] qp;
      logic [REM_W+1:0]  t;
      logic [REM_W+1:0]  trial;
      sp = (k == 0) ? s_in : s_r[(k == 0) ? 0 : k - 1];
      rp = (k == 0) ? '0   : rem_r[(k == 0) ? 0 : k - 1];
      qp = (k == 0) ? '0   : root_r[(k == 0) ? 0 : k - 1];
      t     = {rp, sp[WIDE_W-1 -: 2]};
      trial = (REM_W + 2)'({qp, 2'b01});
      s_nxt[k] = sp << 2;
      if (t >= trial) begin
        rem_nxt[k]  = REM_W'(t - trial);
        root_nxt[k] = {qp[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = REM_W'(t);
        root_nxt[k] = {qp[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SQ_ST; k++) begin
        s_r[k]    <= s_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign q_out = root_r[SQ_ST-1];

endmodule

>>> design/vnu_div.sv
// Pipelined restoring divider for one lane: rounds m * 2^FRAC_W by q,
// one quotient bit per stage. Depends on vnu_pkg.
module vnu_div
  import vnu_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [COMP_W-1:0] m_in,
  input  logic [ROOT_W-1:0] q_in,
  output logic [QUO_W-1:0]  quo_out
);

  logic [ROOT_W-1:0] rem_r [DIV_ST];
  logic [QUO_W-1:0]  low_r [DIV_ST];
  logic [ROOT_W-1:0] q_r   [DIV_ST];
  logic [QUO_W-1:0]  quo_r [DIV_ST];
  logic [ROOT_W-1:0] rem_nxt [DIV_ST];
  logic [QUO_W-1:0]  low_nxt [DIV_ST];
  logic [ROOT_W-1:0] q_nxt   [DIV_ST];
  logic [QUO_W-1:0]  quo_nxt [DIV_ST];
  logic [NUM_W-1:0]  num;

  assign num = (NUM_W'(m_in) << FRAC_W) + NUM_W'(q_in >> 1);

  always_comb begin
    for (int k = 0; k < DIV_ST; k++) begin
      logic [ROOT_W-1:0] rp;
      logic [QUO_W-1:0]  lp;
      logic [ROOT_W-1:0] qp;
      logic [QUO_W-1:0]  op;
      logic [ROOT_W:0]   t;
      rp = (k == 0) ? ROOT_W'(num >> QUO_W) : rem_r[(k == 0) ? 0 : k - 1];
      lp = (k == 0) ? num[QUO_W-1:0]        : low_r[(k == 0) ? 0 : k - 1];
      qp = (k == 0) ? q_in                  : q_r[(k == 0) ? 0 : k - 1];
      op = (k == 0) ? '0                    : quo_r[(k == 0) ? 0 : k - 1];
      t  = {rp, lp[QUO_W-1]};
      low_nxt[k] = lp << 1;
      q_nxt[k]   = qp;
      if (t >= {1'b0, qp}) begin
        rem_nxt[k] = ROOT_W'(t - {1'b0, qp});
        quo_nxt[k] = {op[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = ROOT_W'(t);
        quo_nxt[k] = {op[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_ST; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        q_r[k]   <= q_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_out = quo_r[DIV_ST-1];

endmodule
